// File: hdl/ecbr_pkg.sv
// shared constants, types and codes for the event counter bank
// no dependencies; used by ecbr_close and the top level
package ecbr_pkg;

  localparam int unsigned NumCounters  = 16;
  localparam int unsigned CntW         = (NumCounters > 1) ? $clog2(NumCounters) : 1;
  localparam int unsigned NumIntervals = 4;
  localparam int unsigned ValW         = 64;
  localparam int unsigned IdxW         = 4;
  localparam int unsigned IncW         = 32;
  localparam int unsigned SelW         = 2;
  localparam int unsigned ModeW        = 2;

  localparam int unsigned SecsPerMin   = 60;
  localparam int unsigned MinsPerHour  = 60;
  localparam int unsigned HoursPerDay  = 24;

  // one row holds the second, minute, hour and day entries of a counter
  typedef logic [NumIntervals-1:0][ValW-1:0] quad_t;

  typedef struct packed {
    logic minute;
    logic hour;
    logic whole_day;
  } close_t;

  typedef enum logic [ModeW-1:0] {
    ModeAdd,
    ModeDiff,
    ModeTick,
    ModeRate
  } mode_e;

endpackage

// File: hdl/event_counter_bank_with_interval_rates_unit.sv
// top level of the event counter bank with interval rates; depends on ecbr_pkg and ecbr_close
// add, difference and rate read: operands read on acceptance, result registered in SExec
// tick: sweeps the bank through ecbr_close, per counter a read, close and write back state,
//   result valid after the last write back; new items are taken only in SIdle
// reset clears control state and the per-entry valid bits; an entry not yet written reads as
//   zero, so the block takes items right after reset
module event_counter_bank_with_interval_rates_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ecbr_pkg::ModeW-1:0]    mode_i,
  input  logic [ecbr_pkg::IdxW-1:0]     counter_index_i,
  input  logic signed [ecbr_pkg::IncW-1:0] increment_i,
  input  logic [ecbr_pkg::SelW-1:0]     interval_select_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ecbr_pkg::ValW-1:0]    value_o,
  output logic [ecbr_pkg::ValW-1:0]    counter_total_o
);

  typedef enum logic [2:0] {
    SIdle,
    SExec,
    SSwRd,
    SSwCalc,
    SSwWr
  } state_e;

  localparam int unsigned N  = ecbr_pkg::NumCounters;
  localparam int unsigned AW = ecbr_pkg::CntW;
  localparam int unsigned VW = ecbr_pkg::ValW;

  state_e                       state_q;
  ecbr_pkg::mode_e              mode_q;
  logic                         ok_q;
  logic [ecbr_pkg::IncW-1:0]    inc_q;
  logic [ecbr_pkg::SelW-1:0]    sel_q;
  logic [AW-1:0]                cnt_q;
  logic [VW-1:0]                keep_q;
  ecbr_pkg::close_t             close_q;
  logic [5:0]                   sec_q;
  logic [5:0]                   min_q;
  logic [4:0]                   hour_q;

  logic                         out_valid_q;
  logic [VW-1:0]                value_q;
  logic [VW-1:0]                total_q;

  // memories and their valid bits
  logic [VW-1:0]                tot_mem   [N];
  logic [VW-1:0]                last_mem  [N];
  ecbr_pkg::quad_t              start_mem [N];
  ecbr_pkg::quad_t              rate_mem  [N];
  logic [N-1:0]                 tot_vld_q;
  logic [N-1:0]                 last_vld_q;
  logic [N-1:0]                 row_vld_q;

  logic [VW-1:0]                tot_rd_q;
  logic [VW-1:0]                last_rd_q;
  ecbr_pkg::quad_t              start_rd_q;
  ecbr_pkg::quad_t              rate_rd_q;
  logic                         tot_rv_q;
  logic                         last_rv_q;
  logic                         row_rv_q;

  logic                         in_acc;
  logic [AW-1:0]                rd_addr;
  logic [VW-1:0]                tot_eff;
  logic [VW-1:0]                last_eff;
  ecbr_pkg::quad_t              start_eff;
  ecbr_pkg::quad_t              rate_eff;
  ecbr_pkg::quad_t              start_new;
  ecbr_pkg::quad_t              rate_new;
  logic                         last_cnt;

  logic                         tot_we;
  logic                         last_we;
  logic                         row_we;
  logic [VW-1:0]                tot_wd;
  logic                         produce;
  logic [VW-1:0]                value_d;
  logic [VW-1:0]                total_d;

  logic [5:0]                   sec_d;
  logic [5:0]                   min_d;
  logic [4:0]                   hour_d;
  ecbr_pkg::close_t             close_d;

  assign in_stall_o  = (state_q != SIdle) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign counter_total_o = total_q;

  assign rd_addr   = (state_q == SIdle) ? AW'(counter_index_i) : cnt_q;
  assign tot_eff   = tot_rv_q  ? tot_rd_q   : '0;
  assign last_eff  = last_rv_q ? last_rd_q  : '0;
  assign start_eff = row_rv_q  ? start_rd_q : '0;
  assign rate_eff  = row_rv_q  ? rate_rd_q  : '0;
  assign last_cnt  = (cnt_q == AW'(N - 1));

  // time of day counters, replacing a phase count modulo 86400
  always_comb begin
    close_d = '0;
    sec_d   = (sec_q == 6'(ecbr_pkg::SecsPerMin - 1)) ? 6'd0 : sec_q + 6'd1;
    close_d.minute = (sec_d == 6'd0);
    min_d   = min_q;
    hour_d  = hour_q;
    if (close_d.minute) begin
      min_d = (min_q == 6'(ecbr_pkg::MinsPerHour - 1)) ? 6'd0 : min_q + 6'd1;
      close_d.hour = (min_d == 6'd0);
    end
    if (close_d.hour) begin
      hour_d = (hour_q == 5'(ecbr_pkg::HoursPerDay - 1)) ? 5'd0 : hour_q + 5'd1;
      close_d.whole_day = (hour_d == 5'd0);
    end
  end

  ecbr_close u_close (
    .clk_i   (clk_i),
    .en_i    (state_q == SSwCalc),
    .close_i (close_q),
    .total_i (tot_eff),
    .start_i (start_eff),
    .rate_i  (rate_eff),
    .start_o (start_new),
    .rate_o  (rate_new)
  );

  always_comb begin
    tot_we  = 1'b0;
    last_we = 1'b0;
    row_we  = 1'b0;
    tot_wd  = tot_eff + {{(VW - ecbr_pkg::IncW){inc_q[ecbr_pkg::IncW-1]}}, inc_q};
    produce = 1'b0;
    value_d = '0;
    total_d = tot_eff;
    case (state_q)
      SExec: begin
        produce = 1'b1;
        case (mode_q)
          ecbr_pkg::ModeAdd: begin
            tot_we  = ok_q;
            total_d = tot_wd;
          end
          ecbr_pkg::ModeDiff: begin
            last_we = ok_q;
            value_d = tot_eff - last_eff;
          end
          ecbr_pkg::ModeRate: begin
            value_d = rate_eff[sel_q];
          end
          default: begin
            value_d = '0;
          end
        endcase
      end
      SSwWr: begin
        row_we  = 1'b1;
        produce = last_cnt;
        total_d = keep_q;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
    if (!ok_q) begin
      value_d = '0;
      total_d = '0;
    end
  end

  // memory ports: one read address, one write address per memory
  always_ff @(posedge clk_i) begin
    tot_rd_q   <= tot_mem[rd_addr];
    last_rd_q  <= last_mem[rd_addr];
    start_rd_q <= start_mem[rd_addr];
    rate_rd_q  <= rate_mem[rd_addr];
    if (tot_we) begin
      tot_mem[rd_addr] <= tot_wd;
    end
    if (last_we) begin
      last_mem[rd_addr] <= tot_eff;
    end
    if (row_we) begin
      start_mem[cnt_q] <= start_new;
      rate_mem[cnt_q]  <= rate_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_vld_q  <= '0;
      last_vld_q <= '0;
      row_vld_q  <= '0;
      tot_rv_q   <= 1'b0;
      last_rv_q  <= 1'b0;
      row_rv_q   <= 1'b0;
    end else begin
      tot_rv_q  <= tot_vld_q[rd_addr];
      last_rv_q <= last_vld_q[rd_addr];
      row_rv_q  <= row_vld_q[rd_addr];
      if (tot_we) begin
        tot_vld_q[rd_addr] <= 1'b1;
      end
      if (last_we) begin
        last_vld_q[rd_addr] <= 1'b1;
      end
      if (row_we) begin
        row_vld_q[cnt_q] <= 1'b1;
      end
    end
  end

  // sequencer with the item registers and the output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      mode_q      <= ecbr_pkg::ModeAdd;
      ok_q        <= 1'b0;
      cnt_q       <= '0;
      close_q     <= '0;
      sec_q       <= '0;
      min_q       <= '0;
      hour_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (produce) begin
        out_valid_q <= 1'b1;
        value_q     <= value_d;
        total_q     <= total_d;
      end
      case (state_q)
        SIdle: begin
          if (in_acc) begin
            mode_q <= ecbr_pkg::mode_e'(mode_i);
            ok_q   <= (32'(counter_index_i) < N);
            inc_q  <= increment_i;
            sel_q  <= interval_select_i;
            if (ecbr_pkg::mode_e'(mode_i) == ecbr_pkg::ModeTick) begin
              cnt_q   <= '0;
              sec_q   <= sec_d;
              min_q   <= min_d;
              hour_q  <= hour_d;
              close_q <= close_d;
              state_q <= SSwRd;
            end else begin
              // the addressed counter stays on the port for the write back
              cnt_q   <= AW'(counter_index_i);
              state_q <= SExec;
            end
          end
        end
        SExec: begin
          state_q <= SIdle;
        end
        SSwRd: begin
          if (cnt_q == '0) begin
            keep_q <= tot_eff;
          end
          state_q <= SSwCalc;
        end
        SSwCalc: begin
          state_q <= SSwWr;
        end
        SSwWr: begin
          if (last_cnt) begin
            state_q <= SIdle;
          end else begin
            cnt_q   <= cnt_q + AW'(1);
            state_q <= SSwRd;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == SExec || state_q == SSwWr))
    else $error("output beat raised outside a finishing state");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !out_valid_q)
    else $error("output register busy after accepting a beat");

  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_i == ecbr_pkg::ModeTick) |=> (state_q == SSwRd && cnt_q == '0))
    else $error("sweep did not start at counter zero");

  a_close_nested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SSwCalc) |-> ((!close_q.hour || close_q.minute) &&
                              (!close_q.whole_day || close_q.hour)))
    else $error("interval close flags not nested");

endmodule

// File: hdl/ecbr_close.sv
// interval close stage: rates and restart totals for one counter row
// depends on ecbr_pkg; one register stage, results valid the cycle after en_i
module ecbr_close (
  input  logic           clk_i,
  input  logic           en_i,
  input  ecbr_pkg::close_t close_i,
  input  logic [ecbr_pkg::ValW-1:0] total_i,
  input  ecbr_pkg::quad_t  start_i,
  input  ecbr_pkg::quad_t  rate_i,
  output ecbr_pkg::quad_t  start_o,
  output ecbr_pkg::quad_t  rate_o
);

  logic [ecbr_pkg::NumIntervals-1:0] closed_q;
  ecbr_pkg::quad_t                   diff_q;
  ecbr_pkg::quad_t                   start_q;
  ecbr_pkg::quad_t                   rate_q;
  logic [ecbr_pkg::ValW-1:0]         total_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      closed_q <= {close_i.whole_day, close_i.hour, close_i.minute, 1'b1};
      for (int j = 0; j < ecbr_pkg::NumIntervals; j++) begin
        diff_q[j] <= total_i - start_i[j];
      end
      start_q <= start_i;
      rate_q  <= rate_i;
      total_q <= total_i;
    end
  end

  // closed entries take their change; the first open one above collects it
  always_comb begin
    start_o = start_q;
    rate_o  = rate_q;
    for (int j = 0; j < ecbr_pkg::NumIntervals; j++) begin
      if (closed_q[j]) begin
        start_o[j] = total_q;
        rate_o[j]  = diff_q[j];
      end else if (j > 0 && closed_q[j-1]) begin
        rate_o[j] = rate_q[j] + diff_q[j-1];
      end
    end
  end

endmodule
